FILE: rtl/core/dbsg_pkg.sv
`default_nettype none
package dbsg_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned DAC_BITS_DEF    = 16;

	localparam int unsigned Q_BITS   = 20;
	localparam int unsigned CFG_BITS = 24;

	localparam logic signed [Q_BITS-1:0] Q_ONE = 20'sd131072;

	localparam logic [2:0] CFG_FILL    = 3'd0;
	localparam logic [2:0] CFG_FRAME   = 3'd1;
	localparam logic [2:0] CFG_CYCLES  = 3'd2;
	localparam logic [2:0] CFG_COS     = 3'd3;
	localparam logic [2:0] CFG_SIN     = 3'd4;
	localparam logic [2:0] CFG_XSCALE  = 3'd5;
	localparam logic [2:0] CFG_YSCALE  = 3'd6;
	localparam logic [2:0] CFG_RATE    = 3'd7;

	typedef struct packed {
		logic                     line;
		logic                     fstart;
		logic signed [Q_BITS-1:0] xi;
		logic signed [Q_BITS-1:0] eta;
	} item_t;

	function automatic logic [15:0] low_mask(input logic [15:0] v, input int unsigned bits);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = (i < bits) ? v[i] : 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/drifting_bar_scan_generator.sv
`default_nettype none
// Drifting bar scan generator.
// Input stream: one item per requested sample; s_tdata[0] = restart. A restart
// item relatches the line and gap sizes from the current registers, zeroes the
// drift phase and yields sample 0 of a new frame; otherwise the next sample.
// Output stream: one item per input item, in order. tdata holds x, y and the
// light flag; tuser marks the first sample of a frame.
// Sequencer: an advance item passes ST_IDLE and ST_EMIT; when a line or gap ends it
// adds ST_ENTER, which walks the skipped dark line slots (up to the half-cycle line
// count), and when a frame ends it adds ST_BEGIN and the same slot walk. A restart item
// adds five 19-step serial divisions. No new input item is accepted until ST_IDLE.
// Path to m_tvalid: an advance item is registered in the sequencer, then passes the
// queue, the multiplier pipe stages s1 to s4 and the output register.
// Reset: configuration returns to its defaults and the sizes are computed as for a
// restart, with s_tready low meanwhile. Stall: a two-entry queue parts sequencer and
// multiplier pipe; a held m_tready freezes the pipe and then stops input once the
// queue is full. Registers are written through cfg_we/cfg_index/cfg_data; the user
// writes them only while the block is idle, and the block does not enforce this.
module drifting_bar_scan_generator #(
	parameter int unsigned SAMPLE_BITS = dbsg_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned DAC_BITS    = dbsg_pkg::DAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [15:0] x_out, [31:16] y_out, [32] light_on, [39:33] zero
	output logic             m_tuser,   // [0] frame_start
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	logic [15:0] fill_q, frame_q, cos_q, sin_q, xs_q, ys_q;
	logic [7:0]  sc_q;
	logic [23:0] rate_q;

	logic            q_full, q_avail, q_push, q_pop;
	dbsg_pkg::item_t q_in, q_head;
	logic [15:0]     x_out, y_out;
	logic            light_on, frame_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 16'd600;
			frame_q <= 16'd1000;
			sc_q    <= 8'd2;
			cos_q   <= 16'd32767;
			sin_q   <= 16'd0;
			xs_q    <= 16'd16384;
			ys_q    <= 16'd16384;
			rate_q  <= 24'd1677722;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dbsg_pkg::CFG_FILL:   fill_q  <= cfg_data[15:0];
				dbsg_pkg::CFG_FRAME:  frame_q <= cfg_data[15:0];
				dbsg_pkg::CFG_CYCLES: sc_q    <= cfg_data[7:0];
				dbsg_pkg::CFG_COS:    cos_q   <= cfg_data[15:0];
				dbsg_pkg::CFG_SIN:    sin_q   <= cfg_data[15:0];
				dbsg_pkg::CFG_XSCALE: xs_q    <= cfg_data[15:0];
				dbsg_pkg::CFG_YSCALE: ys_q    <= cfg_data[15:0];
				dbsg_pkg::CFG_RATE:   rate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dbsg_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.restart        (s_tdata[0]),
		.fill_samples   (fill_q),
		.frame_samples  (frame_q),
		.spatial_cycles (sc_q),
		.phase_rate     (rate_q),
		.q_full         (q_full),
		.push           (q_push),
		.push_item      (q_in)
	);

	dbsg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.avail     (q_avail),
		.pop       (q_pop),
		.head      (q_head)
	);

	dbsg_back #(.DAC_BITS(DAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_avail     (q_avail),
		.q_pop       (q_pop),
		.q_head      (q_head),
		.cos_dir     (cos_q),
		.sin_dir     (sin_q),
		.x_scale     (xs_q),
		.y_scale     (ys_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.x_out       (x_out),
		.y_out       (y_out),
		.light_on    (light_on),
		.frame_start (frame_start)
	);

	assign m_tdata = {7'd0, light_on, y_out, x_out};
	assign m_tuser = frame_start;
endmodule
`default_nettype wire

FILE: rtl/core/dbsg_div.sv
`default_nettype none
module dbsg_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [18:0] num,
	input  wire logic [15:0] den,
	output logic             done,
	output logic [18:0]      quot
);
	logic [15:0] rem_q;
	logic [18:0] quo_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        take;

	assign trial = {rem_q, quo_q[18]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd19;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			quo_q <= {quo_q[17:0], take};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

FILE: rtl/core/dbsg_fifo.sv
`default_nettype none
module dbsg_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dbsg_pkg::item_t push_item,
	output logic                 full,
	output logic                 avail,
	input  wire logic            pop,
	output dbsg_pkg::item_t      head
);
	dbsg_pkg::item_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	assign full  = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head  = mem_q[rp_q];
endmodule
`default_nettype wire

FILE: rtl/core/dbsg_front.sv
`default_nettype none
module dbsg_front #(
	parameter int unsigned SAMPLE_BITS = dbsg_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	input  wire logic [15:0] fill_samples,
	input  wire logic [15:0] frame_samples,
	input  wire logic [7:0]  spatial_cycles,
	input  wire logic [23:0] phase_rate,
	input  wire logic        q_full,
	output logic             push,
	output dbsg_pkg::item_t  push_item
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EMIT  = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_BEGIN = 6'b010000,
		ST_ENTER = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		MODE_LINE = 2'd0,
		MODE_GAP  = 2'd1,
		MODE_TAIL = 2'd2
	} mode_t;

	localparam logic [2:0] STEP_HALF  = 3'd0;
	localparam logic [2:0] STEP_PPL   = 3'd1;
	localparam logic [2:0] STEP_GAP   = 3'd2;
	localparam logic [2:0] STEP_XSTEP = 3'd3;
	localparam logic [2:0] STEP_ESTEP = 3'd4;

	localparam int unsigned CW = SAMPLE_BITS + 2;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [2:0]              step_q;
	logic                    emit_pend_q;
	logic [13:0]             hc_q;
	logic [13:0]             nl_q;
	logic [15:0]             ppl_q;
	logic [15:0]             gap_q;
	logic [18:0]             xstep_q;
	logic [16:0]             estep_q;
	logic [7:0]              scu_q;
	logic [29:0]             used_q;
	logic [SAMPLE_BITS-1:0]  sample_q;
	logic [14:0]             lic_q;
	logic [7:0]              cyc_q;
	logic [15:0]             pt_q;
	logic [14:0]             pl_q;
	logic                    rev_q;
	logic                    gpend_q;
	logic signed [19:0]      xi_q;
	logic signed [19:0]      eta_q;
	logic [23:0]             phase_q;

	logic [7:0]  sc_eff;
	logic [15:0] fill_m;
	logic [15:0] flen;
	logic [14:0] full;
	logic [15:0] pl_inc;
	logic [15:0] lic_inc;
	logic [14:0] pl_nx;
	logic [14:0] lic_nx;
	logic [7:0]  cyc_nx;
	logic signed [19:0] eta_nx;
	logic        div_start;
	logic        div_done;
	logic [18:0] div_num;
	logic [15:0] div_den;
	logic [18:0] quot;
	logic [13:0] hc_n;
	logic [15:0] ppl_n;
	logic [38:0] phase_prod;
	logic [CW-1:0] sample_inc;
	logic        frame_end;
	logic [16:0] pt_inc;
	logic        seg_end;

	assign sc_eff = (spatial_cycles == 8'd0) ? 8'd1 : spatial_cycles;
	assign fill_m = dbsg_pkg::low_mask(fill_samples, SAMPLE_BITS);
	assign flen   = (dbsg_pkg::low_mask(frame_samples, SAMPLE_BITS) == 16'd0) ? 16'd1 :
		dbsg_pkg::low_mask(frame_samples, SAMPLE_BITS);
	assign full   = {hc_q, 1'b0};

	assign pl_inc  = {1'b0, pl_q} + 16'd1;
	assign lic_inc = {1'b0, lic_q} + 16'd1;
	assign pl_nx   = (pl_inc >= {1'b0, full}) ? 15'd0 : pl_inc[14:0];
	assign lic_nx  = (lic_inc >= {1'b0, full}) ? 15'd0 : lic_inc[14:0];
	assign cyc_nx  = (lic_inc >= {1'b0, full}) ? cyc_q + 8'd1 : cyc_q;
	assign eta_nx  = eta_q + $signed({3'b000, estep_q});

	always_comb begin
		div_num = 19'(fill_m);
		div_den = 16'(sc_eff) * 16'd6;
		unique case (step_q)
			STEP_HALF: begin
				div_num = 19'(fill_m);
				div_den = 16'(sc_eff) * 16'd6;
			end
			STEP_PPL: begin
				div_num = 19'(fill_m);
				div_den = 16'(nl_q);
			end
			STEP_GAP: begin
				div_num = (30'(fill_m) > used_q) ? 19'(30'(fill_m) - used_q) : 19'd0;
				div_den = 16'(scu_q);
			end
			STEP_XSTEP: begin
				div_num = 19'd262144;
				div_den = ppl_q - 16'd1;
			end
			STEP_ESTEP: begin
				div_num = 19'd262144;
				div_den = {1'b0, nl_q, 1'b0};
			end
			default: begin
				div_num = 19'(fill_m);
				div_den = 16'(sc_eff) * 16'd6;
			end
		endcase
	end

	assign div_start = state_q == ST_LOAD;
	assign hc_n  = (quot < 19'd2) ? 14'd2 : quot[13:0];
	assign ppl_n = (quot < 19'd2) ? 16'd2 : quot[15:0];
	assign phase_prod = phase_q * full;

	assign sample_inc = CW'(sample_q) + CW'(1);
	assign frame_end  = 32'(sample_inc) >= 32'(flen);
	assign pt_inc     = {1'b0, pt_q} + 17'd1;
	assign seg_end    = (mode_q == MODE_LINE) ? (pt_inc >= {1'b0, ppl_q}) :
		(mode_q == MODE_GAP) ? (pt_inc >= {1'b0, gap_q}) : 1'b0;

	dbsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	assign in_ready       = (state_q == ST_IDLE) && !q_full;
	assign push           = state_q == ST_EMIT;
	assign push_item.line   = mode_q == MODE_LINE;
	assign push_item.fstart = sample_q == '0;
	assign push_item.xi     = xi_q;
	assign push_item.eta    = eta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			mode_q      <= MODE_LINE;
			step_q      <= STEP_HALF;
			emit_pend_q <= 1'b0;
			hc_q        <= 14'd2;
			nl_q        <= 14'd2;
			ppl_q       <= 16'd2;
			gap_q       <= '0;
			xstep_q     <= '0;
			estep_q     <= '0;
			scu_q       <= 8'd1;
			used_q      <= '0;
			sample_q    <= '0;
			lic_q       <= '0;
			cyc_q       <= '0;
			pt_q        <= '0;
			pl_q        <= '0;
			rev_q       <= 1'b0;
			gpend_q     <= 1'b0;
			xi_q        <= '0;
			eta_q       <= -dbsg_pkg::Q_ONE;
			phase_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (restart) begin
							state_q     <= ST_LOAD;
							step_q      <= STEP_HALF;
							emit_pend_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_LOAD: state_q <= ST_RUN;
				ST_RUN: begin
					if (div_done) begin
						state_q <= ST_LOAD;
						step_q  <= step_q + 3'd1;
						unique case (step_q)
							STEP_HALF: begin
								hc_q  <= hc_n;
								nl_q  <= 14'(hc_n * sc_eff);
								scu_q <= sc_eff;
							end
							STEP_PPL: begin
								ppl_q  <= ppl_n;
								used_q <= nl_q * ppl_n;
							end
							STEP_GAP: gap_q <= quot[15:0];
							STEP_XSTEP: xstep_q <= quot;
							STEP_ESTEP: begin
								estep_q <= quot[16:0];
								phase_q <= '0;
								state_q <= ST_BEGIN;
							end
							default: state_q <= ST_BEGIN;
						endcase
					end
				end
				ST_BEGIN: begin
					sample_q <= '0;
					cyc_q    <= '0;
					lic_q    <= '0;
					pl_q     <= phase_prod[38:24];
					eta_q    <= -dbsg_pkg::Q_ONE;
					rev_q    <= 1'b0;
					gpend_q  <= 1'b0;
					state_q  <= ST_ENTER;
				end
				ST_ENTER: begin
					if (cyc_q >= scu_q) begin
						mode_q  <= MODE_TAIL;
						state_q <= emit_pend_q ? ST_EMIT : ST_IDLE;
					end else if (pl_q < {1'b0, hc_q}) begin
						mode_q  <= MODE_LINE;
						pt_q    <= '0;
						xi_q    <= rev_q ? dbsg_pkg::Q_ONE : -dbsg_pkg::Q_ONE;
						state_q <= emit_pend_q ? ST_EMIT : ST_IDLE;
					end else if (gpend_q && gap_q != 16'd0) begin
						mode_q  <= MODE_GAP;
						pt_q    <= '0;
						state_q <= emit_pend_q ? ST_EMIT : ST_IDLE;
					end else begin
						gpend_q <= 1'b0;
						eta_q   <= eta_nx;
						pl_q    <= pl_nx;
						lic_q   <= lic_nx;
						cyc_q   <= cyc_nx;
					end
				end
				ST_EMIT: begin
					emit_pend_q <= 1'b0;
					sample_q    <= sample_inc[SAMPLE_BITS-1:0];
					if (mode_q == MODE_LINE) begin
						pt_q <= pt_inc[15:0];
						xi_q <= rev_q ? xi_q - $signed({1'b0, xstep_q}) :
							xi_q + $signed({1'b0, xstep_q});
						if (seg_end) rev_q <= ~rev_q;
					end else if (mode_q == MODE_GAP) begin
						pt_q <= pt_inc[15:0];
					end
					if (seg_end) begin
						gpend_q <= (mode_q == MODE_LINE);
						eta_q   <= eta_nx;
						pl_q    <= pl_nx;
						lic_q   <= lic_nx;
						cyc_q   <= cyc_nx;
					end
					if (frame_end) begin
						phase_q <= phase_q + phase_rate;
						state_q <= ST_BEGIN;
					end else if (seg_end) begin
						state_q <= ST_ENTER;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cyc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cyc_q <= scu_q))
		else $error("cycle index past latched cycle count");

	a_line_pt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && mode_q == MODE_LINE) |-> (pt_q < ppl_q))
		else $error("line point counter overran");

	a_gap_pt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && mode_q == MODE_GAP) |-> (gap_q != 16'd0 && pt_q < gap_q))
		else $error("gap counter overran");

	a_phase_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pl_q < full))
		else $error("phase line outside cycle");

	a_restart_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && in_ready && !restart) |=> push)
		else $error("advance item not emitted");
endmodule
`default_nettype wire

FILE: rtl/core/dbsg_back.sv
`default_nettype none
module dbsg_back #(
	parameter int unsigned DAC_BITS = dbsg_pkg::DAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_avail,
	output logic                 q_pop,
	input  wire dbsg_pkg::item_t q_head,
	input  wire logic [15:0]     cos_dir,
	input  wire logic [15:0]     sin_dir,
	input  wire logic [15:0]     x_scale,
	input  wire logic [15:0]     y_scale,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [15:0]          x_out,
	output logic [15:0]          y_out,
	output logic                 light_on,
	output logic                 frame_start
);
	localparam logic signed [25:0] DAC_HI = (26'sd1 <<< (DAC_BITS - 1)) - 26'sd1;
	localparam logic signed [25:0] DAC_LO = -DAC_HI - 26'sd1;
	localparam logic signed [53:0] RND    = 54'sd2147483648;

	logic signed [15:0] cs, sn, xsc, ysc;
	logic adv;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               ln_s1, ln_s2, ln_s3, ln_s4;
	logic               fs_s1, fs_s2, fs_s3, fs_s4;
	logic signed [35:0] xc_s1, es_s1, xs_s1, ec_s1;
	logic signed [36:0] ax_s2, ay_s2;
	logic signed [35:0] xh_s3, yh_s3;
	logic signed [33:0] xl_s3, yl_s3;
	logic signed [53:0] tx_s4, ty_s4;
	logic signed [53:0] xh_e, yh_e, xl_e, yl_e;
	logic signed [19:0] axh, ayh;
	logic signed [17:0] axl, ayl;
	logic signed [25:0] rx, ry, sx, sy;

	logic        out_v_q;
	logic [15:0] x_q, y_q, held_x_q, held_y_q;
	logic        light_q, fs_q;

	assign cs  = $signed(cos_dir);
	assign sn  = $signed(sin_dir);
	assign xsc = $signed(x_scale);
	assign ysc = $signed(y_scale);

	assign adv   = !out_v_q || out_ready;
	assign q_pop = adv && q_avail;

	assign axh = $signed(ax_s2[36:17]);
	assign ayh = $signed(ay_s2[36:17]);
	assign axl = $signed({1'b0, ax_s2[16:0]});
	assign ayl = $signed({1'b0, ay_s2[16:0]});

	assign xh_e = xh_s3;
	assign yh_e = yh_s3;
	assign xl_e = xl_s3;
	assign yl_e = yl_s3;

	assign rx = $signed(tx_s4[53:32]);
	assign ry = $signed(ty_s4[53:32]);
	assign sx = (rx > DAC_HI) ? DAC_HI : (rx < DAC_LO) ? DAC_LO : rx;
	assign sy = (ry > DAC_HI) ? DAC_HI : (ry < DAC_LO) ? DAC_LO : ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			out_v_q  <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (adv) begin
			v_s1    <= q_avail;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4;
			if (v_s4 && ln_s4) begin
				held_x_q <= sx[15:0];
				held_y_q <= sy[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_s1 <= q_head.line;
			fs_s1 <= q_head.fstart;
			xc_s1 <= q_head.xi * cs;
			es_s1 <= q_head.eta * sn;
			xs_s1 <= q_head.xi * sn;
			ec_s1 <= q_head.eta * cs;

			ln_s2 <= ln_s1;
			fs_s2 <= fs_s1;
			ax_s2 <= xc_s1 - es_s1;
			ay_s2 <= xs_s1 + ec_s1;

			ln_s3 <= ln_s2;
			fs_s3 <= fs_s2;
			xh_s3 <= xsc * axh;
			xl_s3 <= xsc * axl;
			yh_s3 <= ysc * ayh;
			yl_s3 <= ysc * ayl;

			ln_s4 <= ln_s3;
			fs_s4 <= fs_s3;
			tx_s4 <= (xh_e <<< 17) + xl_e + RND;
			ty_s4 <= (yh_e <<< 17) + yl_e + RND;

			light_q <= ln_s4;
			fs_q    <= fs_s4;
			x_q     <= ln_s4 ? sx[15:0] : held_x_q;
			y_q     <= ln_s4 ? sy[15:0] : held_y_q;
		end
	end

	assign out_valid   = out_v_q;
	assign x_out       = x_q;
	assign y_out       = y_q;
	assign light_on    = light_q;
	assign frame_start = fs_q;

	a_dark_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && !ln_s4) |=> (x_q == held_x_q && y_q == held_y_q))
		else $error("dark sample moved the scanner");

	a_lit_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && ln_s4) |=> (x_q == held_x_q && y_q == held_y_q && light_q))
		else $error("held point not updated by lit sample");

	a_pop_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop) |=> v_s1)
		else $error("popped item lost");
endmodule
`default_nettype wire

FILE: bench/scan_checker.sv
`timescale 1ns / 1ps
module scan_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	output int               fails,
	output int               pending
);
	localparam logic [1:0] SEG_LINE = 2'd0;
	localparam logic [1:0] SEG_GAP  = 2'd1;
	localparam logic [1:0] SEG_TAIL = 2'd2;
	localparam int         UNIT     = 131072;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        light;
		logic        fstart;
	} sample_t;

	sample_t samples_due[$];

	logic [15:0] fill_r, frame_r, cos_r, sin_r, xs_r, ys_r;
	logic [7:0]  cycles_r;
	logic [23:0] rate_r;

	int unsigned smp, line_no, cyc, pt, ph_line, rev, gap_due, seg, phase;
	int unsigned hc, ppl, gap_len, cyc_used;
	int          xi, eta, hx, hy, xi_inc, eta_inc;

	assign pending = samples_due.size();

	task automatic latch_sizes();
		int unsigned sc, nl, used;
		sc = (cycles_r != 0) ? cycles_r : 1;
		hc = (fill_r / 6) / sc;
		if (hc < 2) hc = 2;
		nl = hc * sc;
		ppl = fill_r / nl;
		if (ppl < 2) ppl = 2;
		used = nl * ppl;
		gap_len = (fill_r > used) ? (fill_r - used) / sc : 0;
		xi_inc = (1 << 18) / (ppl - 1);
		eta_inc = (1 << 18) / (2 * nl);
		cyc_used = sc;
	endtask

	task automatic advance_slot();
		eta += eta_inc;
		ph_line++;
		if (ph_line >= 2 * hc) ph_line = 0;
		line_no++;
		if (line_no >= 2 * hc) begin
			line_no = 0;
			cyc++;
		end
	endtask

	task automatic seek_slot();
		forever begin
			if (cyc >= cyc_used) begin
				seg = SEG_TAIL;
				return;
			end
			if (ph_line < hc) begin
				seg = SEG_LINE;
				pt = 0;
				xi = rev ? UNIT : -UNIT;
				return;
			end
			if (gap_due && gap_len > 0) begin
				seg = SEG_GAP;
				pt = 0;
				return;
			end
			gap_due = 0;
			advance_slot();
		end
	endtask

	task automatic open_frame();
		longint unsigned p;
		smp = 0;
		cyc = 0;
		line_no = 0;
		p = (longint'(phase) * longint'(2 * hc)) >> 24;
		ph_line = 32'(p);
		eta = -UNIT;
		rev = 0;
		gap_due = 0;
		seek_slot();
	endtask

	function automatic int to_code(longint t);
		longint r;
		r = (t + 64'sd2147483648) >>> 32;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return int'(r);
	endfunction

	task automatic predict_sample(input logic restart);
		sample_t s;
		longint  c, sn;
		int unsigned flen;
		if (restart) begin
			latch_sizes();
			phase = 0;
			open_frame();
		end
		s.fstart = (smp == 0);
		s.light = 1'b0;
		if (seg == SEG_LINE) begin
			c = longint'($signed(cos_r));
			sn = longint'($signed(sin_r));
			hx = to_code(longint'($signed(xs_r)) * (longint'(xi) * c - longint'(eta) * sn));
			hy = to_code(longint'($signed(ys_r)) * (longint'(xi) * sn + longint'(eta) * c));
			s.light = 1'b1;
			pt++;
			xi += rev ? -xi_inc : xi_inc;
			if (pt >= ppl) begin
				rev ^= 1;
				gap_due = 1;
				advance_slot();
				seek_slot();
			end
		end else if (seg == SEG_GAP) begin
			pt++;
			if (pt >= gap_len) begin
				gap_due = 0;
				advance_slot();
				seek_slot();
			end
		end
		s.x = hx[15:0];
		s.y = hy[15:0];
		samples_due.push_back(s);
		flen = (frame_r != 0) ? frame_r : 1;
		smp++;
		if (smp >= flen) begin
			phase = (phase + rate_r) & 24'hFFFFFF;
			open_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			fill_r = 16'd600; frame_r = 16'd1000; cycles_r = 8'd2;
			cos_r = 16'd32767; sin_r = 16'd0; xs_r = 16'd16384; ys_r = 16'd16384;
			rate_r = 24'd1677722;
			hx = 0; hy = 0; xi = 0; pt = 0; phase = 0; seg = SEG_LINE;
			samples_due.delete();
			fails = 0;
			latch_sizes();
			open_frame();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dbsg_pkg::CFG_FILL:   fill_r = cfg_data[15:0];
					dbsg_pkg::CFG_FRAME:  frame_r = cfg_data[15:0];
					dbsg_pkg::CFG_CYCLES: cycles_r = cfg_data[7:0];
					dbsg_pkg::CFG_COS:    cos_r = cfg_data[15:0];
					dbsg_pkg::CFG_SIN:    sin_r = cfg_data[15:0];
					dbsg_pkg::CFG_XSCALE: xs_r = cfg_data[15:0];
					dbsg_pkg::CFG_YSCALE: ys_r = cfg_data[15:0];
					dbsg_pkg::CFG_RATE:   rate_r = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) predict_sample(s_tdata[0]);
			if (m_tvalid && m_tready) begin
				if (samples_due.size() == 0) begin
					$error("unexpected item: tdata %h tuser %b", m_tdata, m_tuser);
					fails++;
				end else begin
					e = samples_due.pop_front();
					if (m_tdata[15:0] !== e.x) begin
						$error("x_out: expected %h, actual %h", e.x, m_tdata[15:0]);
						fails++;
					end
					if (m_tdata[31:16] !== e.y) begin
						$error("y_out: expected %h, actual %h", e.y, m_tdata[31:16]);
						fails++;
					end
					if (m_tdata[32] !== e.light) begin
						$error("light_on: expected %b, actual %b", e.light, m_tdata[32]);
						fails++;
					end
					if (m_tuser !== e.fstart) begin
						$error("frame_start: expected %b, actual %b", e.fstart, m_tuser);
						fails++;
					end
				end
			end
		end
	end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = dbsg_pkg::CFG_FILL;
	logic [23:0] cfg_data = 24'd0;
	int          fails, pending;
	int          sent = 0;
	int          send_idle = 12, recv_idle = 67;

	always #5 clk = ~clk;

	drifting_bar_scan_generator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	scan_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		if (sent >= 840) begin
			send_idle <= 0;
			recv_idle <= 0;
		end else if (sent >= 420) begin
			send_idle <= 67;
			recv_idle <= 12;
		end
	end

	task automatic send_sample(input logic restart);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_regs(input logic [23:0] v [8]);
		drain();
		repeat (25000) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_samples(input int n, input int restart_pct);
		send_sample(1'b1);
		for (int i = 1; i < n; i++) send_sample($urandom_range(0, 99) < restart_pct);
	endtask

	initial begin
		logic [23:0] v [8];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		v = '{24'd12, 24'd12, 24'd1, 24'h008000, 24'h007FFF, 24'h007FFF, 24'h008000,
			24'hFFFFFF};
		write_regs(v);
		for (int i = 0; i < 25; i++) send_sample(i == 0 || i == 17);

		v = '{24'd600, 24'd1000, 24'd2, 24'h007FFF, 24'd0, 24'h004000, 24'h004000,
			24'd1677722};
		write_regs(v);
		run_samples(200, 1);
		drain();
		run_samples(60, 3);

		v = '{24'hFFFF, 24'hFFFF, 24'd255, 24'h007FFF, 24'h008000, 24'h008000,
			24'h007FFF, 24'd0};
		write_regs(v);
		run_samples(150, 0);

		v = '{24'd100, 24'd40, 24'd3, 24'h005A82, 24'h00A57E, 24'h007FFF, 24'h001000,
			24'h400000};
		write_regs(v);
		run_samples(150, 2);

		v = '{24'd30, 24'd200, 24'd255, 24'h000000, 24'h007FFF, 24'h003000, 24'h00D000,
			24'h123456};
		write_regs(v);
		run_samples(150, 2);

		while (sent < 1275) begin
			v[0] = 24'($urandom_range(12, 400));
			v[1] = 24'($urandom_range(12, 1200));
			v[2] = 24'($urandom_range(1, 255));
			for (int i = 3; i < 7; i++) v[i] = 24'($urandom & 32'h0000FFFF);
			v[7] = 24'($urandom & 32'h00FFFFFF);
			write_regs(v);
			run_samples(140, 3);
		end

		drain();
		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: drifting_bar_scan_generator.f
rtl/core/dbsg_pkg.sv
rtl/core/dbsg_div.sv
rtl/core/dbsg_fifo.sv
rtl/core/dbsg_front.sv
rtl/core/dbsg_back.sv
rtl/core/drifting_bar_scan_generator.sv
bench/scan_checker.sv
bench/tb.sv
